### rtl/fgma_pkg.sv
// ----------------------------------------------------------------------------
// fgma_pkg
// Shared types and widths for the modified-average face gradient block.
// ----------------------------------------------------------------------------
package fgma_pkg;

    localparam int FIELD_W  = 32;             // Q16.16 port fields
    localparam int DIFF_W   = FIELD_W + 1;    // centre, value and slope sums
    localparam int PROD_W   = 2 * DIFF_W;     // 33 x 33 products
    localparam int T_W      = PROD_W + 2;     // signed numerator term
    localparam int TMAG_W   = T_W - 1;        // its magnitude
    localparam int CHUNK_W  = 23;             // slice of |T| per partial product
    localparam int PART_W   = CHUNK_W + DIFF_W;
    localparam int NUM_W    = TMAG_W + DIFF_W; // |T * D|
    localparam int DEN_W    = PROD_W;          // |D|^2
    localparam int DIV_STEPS = NUM_W;          // one quotient bit per stage
    localparam int S_W      = NUM_W + 1;       // signed quotient
    localparam int SUM_W    = S_W + 1;

    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;
    localparam int QCW      = 3;

    // stages from queue to result register
    localparam int PIPE_DEPTH = 5 + DIV_STEPS + 2;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] du;
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] ay;
        logic                     zero;
    } face_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] ay;
        logic                     neg_x;
        logic                     neg_y;
        logic                     zero;
    } side_t;

endpackage

### rtl/fgma_front.sv
// ----------------------------------------------------------------------------
// fgma_front
// Forms centre difference, value jump and slope sums, and flags coincident
// centres.
// ----------------------------------------------------------------------------
module fgma_front (
    input  logic signed [31:0] left_centre_x,
    input  logic signed [31:0] left_centre_y,
    input  logic signed [31:0] right_centre_x,
    input  logic signed [31:0] right_centre_y,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    input  logic signed [31:0] left_slope_x,
    input  logic signed [31:0] left_slope_y,
    input  logic signed [31:0] right_slope_x,
    input  logic signed [31:0] right_slope_y,
    output fgma_pkg::face_t    item
);
    import fgma_pkg::*;

    always_comb
    begin
        item.dx   = DIFF_W'(right_centre_x) - DIFF_W'(left_centre_x);
        item.dy   = DIFF_W'(right_centre_y) - DIFF_W'(left_centre_y);
        item.du   = DIFF_W'(right_value) - DIFF_W'(left_value);
        item.ax   = DIFF_W'(left_slope_x) + DIFF_W'(right_slope_x);
        item.ay   = DIFF_W'(left_slope_y) + DIFF_W'(right_slope_y);
        item.zero = (right_centre_x == left_centre_x) && (right_centre_y == left_centre_y);
    end

endmodule

### rtl/fgma_queue.sv
// ----------------------------------------------------------------------------
// fgma_queue
// Short FIFO between the front and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module fgma_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  fgma_pkg::face_t item_in,
    input  logic            pop,
    output logic            empty,
    output fgma_pkg::face_t item_out
);
    import fgma_pkg::*;

    face_t          slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == QCW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### rtl/fgma_divider.sv
// ----------------------------------------------------------------------------
// fgma_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fgma_divider (
    input  logic                          clk,
    input  logic                          en,
    input  logic [fgma_pkg::NUM_W-1:0]    num,
    input  logic [fgma_pkg::DEN_W-1:0]    den,
    output logic [fgma_pkg::NUM_W-1:0]    quot,
    output logic                          rem_nz
);
    import fgma_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_STEPS];
    logic [NUM_W-1:0] num_reg [DIV_STEPS];
    logic [DEN_W-1:0] den_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   cat;
        logic [DEN_W+1:0] diff;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // shift in the next numerator bit; the freed low bit takes the quotient bit
        assign cat  = {rem_in, num_in[NUM_W-1]};
        assign diff = {1'b0, cat} - {2'b00, den_in};
        assign take = !diff[DEN_W+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
                num_reg[i] <= {num_in[NUM_W-2:0], take};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quot   = num_reg[DIV_STEPS-1];
    assign rem_nz = |rem_reg[DIV_STEPS-1];

endmodule

### rtl/fgma_back.sv
// ----------------------------------------------------------------------------
// fgma_back
// Arithmetic pipeline: products, numerator, exact floor division, rounding
// and saturation, with the result register at its end.
// ----------------------------------------------------------------------------
module fgma_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_take,
    input  fgma_pkg::face_t    item,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] face_slope_x,
    output logic signed [31:0] face_slope_y,
    output logic               out_of_range
);
    import fgma_pkg::*;

    logic adv;

    // stage 1: products
    logic                     v1_reg;
    face_t                    s1_reg;
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, pax_reg, pay_reg;

    // stage 2: |D|^2 and T
    logic                     v2_reg;
    face_t                    s2_reg;
    logic [DEN_W-1:0]         q2_reg;
    logic signed [T_W-1:0]    t2_reg;

    // stage 3: magnitudes
    logic                     v3_reg;
    side_t                    side3_reg;
    logic [DEN_W-1:0]         q3_reg;
    logic [TMAG_W-1:0]        tmag3_reg;
    logic [DIFF_W-1:0]        dxm3_reg, dym3_reg;

    // stage 4: partial products
    logic                     v4_reg;
    side_t                    side4_reg;
    logic [DEN_W-1:0]         q4_reg;
    logic [PART_W-1:0]        px_reg [3];
    logic [PART_W-1:0]        py_reg [3];

    // stage 5: numerators
    logic                     v5_reg;
    side_t                    side5_reg;
    logic [DEN_W-1:0]         q5_reg;
    logic [NUM_W-1:0]         nx5_reg, ny5_reg;

    // divider span
    logic [DIV_STEPS-1:0]     vd_reg;
    side_t                    sided_reg [DIV_STEPS];
    logic [NUM_W-1:0]         quot_x, quot_y;
    logic                     rnz_x, rnz_y;

    // signed quotient
    logic                     vf_reg;
    side_t                    sidef_reg;
    logic signed [S_W-1:0]    sx_reg, sy_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [31:0]       fx_reg, fy_reg;
    logic                     oor_reg;

    logic signed [T_W-1:0]    t2_next;
    logic [TMAG_W+1:0]        tpad;
    logic signed [S_W-1:0]    sx_next, sy_next;
    logic signed [31:0]       fx_next, fy_next;
    logic                     sat_x, sat_y;

    assign adv     = !out_valid_reg || pop;
    assign in_take = adv && in_valid;
    assign empty   = !out_valid_reg;
    assign face_slope_x = fx_reg;
    assign face_slope_y = fy_reg;
    assign out_of_range = oor_reg;

    assign t2_next = (T_W'(s1_reg.du) <<< 17) - T_W'(pax_reg) - T_W'(pay_reg);
    assign tpad    = {2'b00, tmag3_reg};

    fgma_divider u_div_x (
        .clk    (clk),
        .en     (adv),
        .num    (nx5_reg),
        .den    (q5_reg),
        .quot   (quot_x),
        .rem_nz (rnz_x)
    );

    fgma_divider u_div_y (
        .clk    (clk),
        .en     (adv),
        .num    (ny5_reg),
        .den    (q5_reg),
        .quot   (quot_y),
        .rem_nz (rnz_y)
    );

    // floor toward minus infinity from the quotient magnitude
    always_comb
    begin
        sx_next = sided_reg[DIV_STEPS-1].neg_x
                  ? -(S_W'(quot_x) + S_W'(rnz_x)) : S_W'(quot_x);
        sy_next = sided_reg[DIV_STEPS-1].neg_y
                  ? -(S_W'(quot_y) + S_W'(rnz_y)) : S_W'(quot_y);
    end

    function automatic logic [32:0] halve_sat(input logic signed [DIFF_W-1:0] a,
                                              input logic signed [S_W-1:0]    s);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] h;
        logic [32:0]             r;
        sum = SUM_W'(a) + SUM_W'(s);
        h   = sum >>> 1;
        if (h > SUM_W'(32'sh7FFF_FFFF))
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (h < -SUM_W'(64'sh8000_0000))
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, h[31:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        {sat_x, fx_next} = halve_sat(sidef_reg.ax, sx_reg);
        {sat_y, fy_next} = halve_sat(sidef_reg.ay, sy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            vd_reg        <= '0;
            vf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            vd_reg        <= {vd_reg[DIV_STEPS-2:0], v5_reg};
            vf_reg        <= vd_reg[DIV_STEPS-1];
            out_valid_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= item;
            pxx_reg <= item.dx * item.dx;
            pyy_reg <= item.dy * item.dy;
            pax_reg <= item.ax * item.dx;
            pay_reg <= item.ay * item.dy;

            s2_reg  <= s1_reg;
            q2_reg  <= DEN_W'($unsigned(pxx_reg)) + DEN_W'($unsigned(pyy_reg));
            t2_reg  <= t2_next;

            side3_reg.ax    <= s2_reg.ax;
            side3_reg.ay    <= s2_reg.ay;
            side3_reg.neg_x <= t2_reg[T_W-1] ^ s2_reg.dx[DIFF_W-1];
            side3_reg.neg_y <= t2_reg[T_W-1] ^ s2_reg.dy[DIFF_W-1];
            side3_reg.zero  <= s2_reg.zero;
            q3_reg    <= q2_reg;
            tmag3_reg <= TMAG_W'(t2_reg[T_W-1] ? -t2_reg : t2_reg);
            dxm3_reg  <= s2_reg.dx[DIFF_W-1] ? -s2_reg.dx : s2_reg.dx;
            dym3_reg  <= s2_reg.dy[DIFF_W-1] ? -s2_reg.dy : s2_reg.dy;

            side4_reg <= side3_reg;
            q4_reg    <= q3_reg;
            for (int k = 0; k < 3; k++)
            begin
                px_reg[k] <= PART_W'(tpad[k*CHUNK_W +: CHUNK_W]) * PART_W'(dxm3_reg);
                py_reg[k] <= PART_W'(tpad[k*CHUNK_W +: CHUNK_W]) * PART_W'(dym3_reg);
            end

            side5_reg <= side4_reg;
            q5_reg    <= q4_reg;
            nx5_reg   <= NUM_W'(px_reg[0]) + (NUM_W'(px_reg[1]) << CHUNK_W)
                         + (NUM_W'(px_reg[2]) << (2 * CHUNK_W));
            ny5_reg   <= NUM_W'(py_reg[0]) + (NUM_W'(py_reg[1]) << CHUNK_W)
                         + (NUM_W'(py_reg[2]) << (2 * CHUNK_W));

            sided_reg[0] <= side5_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                sided_reg[k] <= sided_reg[k-1];
            end

            sidef_reg <= sided_reg[DIV_STEPS-1];
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;

            // coincident centres: zero result, flag raised
            if (sidef_reg.zero)
            begin
                fx_reg  <= '0;
                fy_reg  <= '0;
                oor_reg <= 1'b1;
            end
            else
            begin
                fx_reg  <= fx_next;
                fy_reg  <= fy_next;
                oor_reg <= sat_x || sat_y;
            end
        end
    end

endmodule

### rtl/face_gradient_modified_average.sv
// ----------------------------------------------------------------------------
// face_gradient_modified_average
// Modified-average face gradient of one variable on one 2D face, Q16.16.
//
//   channel   direction  handshake        payload
//   input     in         push / full      centres, values, slopes
//   result    out        pop / empty      face_slope_x/y, out_of_range
//
// One face per cycle sustained while results are popped, through five
// arithmetic stages and the 100-stage restoring divider. A four-entry
// queue sits between the front and the pipeline. While a result waits
// unpopped the pipeline holds, and the queue keeps taking items until
// it fills. Reset clears all valid flags at once.
// ----------------------------------------------------------------------------
module face_gradient_modified_average (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] left_centre_x,
    input  logic signed [31:0] left_centre_y,
    input  logic signed [31:0] right_centre_x,
    input  logic signed [31:0] right_centre_y,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    input  logic signed [31:0] left_slope_x,
    input  logic signed [31:0] left_slope_y,
    input  logic signed [31:0] right_slope_x,
    input  logic signed [31:0] right_slope_y,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] face_slope_x,
    output logic signed [31:0] face_slope_y,
    output logic               out_of_range
);
    import fgma_pkg::*;

    face_t front_item;
    face_t queue_item;
    logic  queue_empty;
    logic  back_take;

    fgma_front u_front (
        .left_centre_x  (left_centre_x),
        .left_centre_y  (left_centre_y),
        .right_centre_x (right_centre_x),
        .right_centre_y (right_centre_y),
        .left_value     (left_value),
        .right_value    (right_value),
        .left_slope_x   (left_slope_x),
        .left_slope_y   (left_slope_y),
        .right_slope_x  (right_slope_x),
        .right_slope_y  (right_slope_y),
        .item           (front_item)
    );

    fgma_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item_in  (front_item),
        .pop      (back_take),
        .empty    (queue_empty),
        .item_out (queue_item)
    );

    fgma_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!queue_empty),
        .in_take      (back_take),
        .item         (queue_item),
        .pop          (pop),
        .empty        (empty),
        .face_slope_x (face_slope_x),
        .face_slope_y (face_slope_y),
        .out_of_range (out_of_range)
    );

endmodule

### rtl/fgma_checker.sv
// ----------------------------------------------------------------------------
// fgma_checker
// Port-level checks on transaction ordering and result holding.
// ----------------------------------------------------------------------------
module fgma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input logic signed [31:0] face_slope_x,
    input logic signed [31:0] face_slope_y,
    input logic               out_of_range
);
    import fgma_pkg::*;

    localparam int MAX_OUT = QDEPTH + PIPE_DEPTH;

    logic [7:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // count transactions in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 8'(in_acc) - 8'(out_acc);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(face_slope_x)
                              && $stable(face_slope_y) && $stable(out_of_range)))
        else $error("waiting result changed");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pend_reg != 8'd0))
        else $error("result shown with nothing in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 8'(MAX_OUT))
        else $error("more transactions in flight than storage");

endmodule

bind face_gradient_modified_average fgma_checker u_fgma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .pop          (pop),
    .empty        (empty),
    .face_slope_x (face_slope_x),
    .face_slope_y (face_slope_y),
    .out_of_range (out_of_range)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modified-average face gradient block. Drives
// directed and random faces through the push/full side, predicts each face
// gradient with wide exact integer arithmetic, and compares every popped
// transaction in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] lcx, lcy, rcx, rcy, lv, rv, lsx, lsy, rsx, rsy;
    } face_in_t;

    typedef struct {
        logic signed [31:0] gx, gy;
        logic               flag;
    } face_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, out_of_range;
    logic signed [31:0] left_centre_x = '0, left_centre_y = '0;
    logic signed [31:0] right_centre_x = '0, right_centre_y = '0;
    logic signed [31:0] left_value = '0, right_value = '0;
    logic signed [31:0] left_slope_x = '0, left_slope_y = '0;
    logic signed [31:0] right_slope_x = '0, right_slope_y = '0;
    logic signed [31:0] face_slope_x, face_slope_y;

    face_in_t  pending_faces[$];
    face_out_t expected_gradients[$];
    int        errors = 0;
    int        send_idle_pct = 20;
    int        recv_idle_pct = 84;
    int        sat_seen = 0;
    int        popped = 0;
    bit        hold_send = 1'b0;
    bit        in_taken = 1'b0;
    longint    cycles = 0;

    face_gradient_modified_average dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // floor halve then saturate to Q16.16
    function automatic logic signed [31:0] halve_sat(logic signed [199:0] s, ref logic flag);
        logic signed [199:0] h;
        h = s >>> 1;
        if (h > 200'sd2147483647)
        begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (h < -200'sd2147483648)
        begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return h[31:0];
    endfunction

    function automatic logic signed [199:0] floor_div(logic signed [199:0] n,
                                                      logic signed [199:0] d);
        logic signed [199:0] q;
        q = n / d;
        if ((q * d) != n && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic face_out_t face_gradient(face_in_t f);
        logic signed [199:0] dx, dy, du, ax, ay, q, t;
        face_out_t r;
        logic flag;
        flag = 1'b0;
        dx = 200'(f.rcx) - 200'(f.lcx);
        dy = 200'(f.rcy) - 200'(f.lcy);
        du = 200'(f.rv) - 200'(f.lv);
        ax = 200'(f.lsx) + 200'(f.rsx);
        ay = 200'(f.lsy) + 200'(f.rsy);
        q = dx * dx + dy * dy;
        if (q == 0)
        begin
            r.gx = '0;
            r.gy = '0;
            r.flag = 1'b1;
            return r;
        end
        t = du * 200'sd131072 - (ax * dx + ay * dy);
        r.gx = halve_sat(ax + floor_div(t * dx, q), flag);
        r.gy = halve_sat(ay + floor_div(t * dy, q), flag);
        r.flag = flag;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            3: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic face_in_t random_face();
        face_in_t f;
        f.lcx = pick_value();
        f.lcy = pick_value();
        f.rcx = pick_value();
        f.rcy = pick_value();
        f.lv  = pick_value();
        f.rv  = pick_value();
        f.lsx = pick_value();
        f.lsy = pick_value();
        f.rsx = pick_value();
        f.rsy = pick_value();
        // sometimes coincident or axis-aligned centres
        case ($urandom_range(0, 9))
            0: begin f.rcx = f.lcx; f.rcy = f.lcy; end
            1: f.rcy = f.lcy;
            2: f.rcx = f.lcx;
            default: ;
        endcase
        return f;
    endfunction

    function automatic face_in_t fill_face(logic signed [31:0] v);
        face_in_t f;
        f = '{v, v, v, v, v, v, v, v, v, v};
        return f;
    endfunction

    // driver: present the next face, advance on acceptance seen at the last rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(pending_faces.pop_front());
            if (pending_faces.size() > 0 && !hold_send
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                push           <= 1'b1;
                left_centre_x  <= pending_faces[0].lcx;
                left_centre_y  <= pending_faces[0].lcy;
                right_centre_x <= pending_faces[0].rcx;
                right_centre_y <= pending_faces[0].rcy;
                left_value     <= pending_faces[0].lv;
                right_value    <= pending_faces[0].rv;
                left_slope_x   <= pending_faces[0].lsx;
                left_slope_y   <= pending_faces[0].lsy;
                right_slope_x  <= pending_faces[0].rsx;
                right_slope_y  <= pending_faces[0].rsy;
            end
            else
                push <= 1'b0;
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted input, check on accepted result
    always @(posedge clk)
    begin
        face_in_t  f;
        face_out_t e;
        cycles <= cycles + 1;
        in_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            f = '{left_centre_x, left_centre_y, right_centre_x, right_centre_y,
                  left_value, right_value, left_slope_x, left_slope_y,
                  right_slope_x, right_slope_y};
            expected_gradients.push_back(face_gradient(f));
        end
        if (rst_n && pop && !empty)
        begin
            popped <= popped + 1;
            if (out_of_range)
                sat_seen <= sat_seen + 1;
            if (expected_gradients.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                errors <= errors + 1;
            end
            else
            begin
                e = expected_gradients.pop_front();
                if (face_slope_x !== e.gx)
                begin
                    $error("face_slope_x: expected %0d, actual %0d", e.gx, face_slope_x);
                    errors <= errors + 1;
                end
                if (face_slope_y !== e.gy)
                begin
                    $error("face_slope_y: expected %0d, actual %0d", e.gy, face_slope_y);
                    errors <= errors + 1;
                end
                if (out_of_range !== e.flag)
                begin
                    $error("out_of_range: expected %0b, actual %0b", e.flag, out_of_range);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic drain();
        while (pending_faces.size() > 0 || push || expected_gradients.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        face_in_t f;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, coincident centres, axis-aligned and unit cases
        pending_faces.push_back(fill_face(32'sh0));
        pending_faces.push_back(fill_face(32'sh7FFFFFFF));
        pending_faces.push_back(fill_face(32'sh80000000));
        pending_faces.push_back(fill_face(-32'sd1));
        f = fill_face(32'sh0);
        f.rcx = 32'sh10000;
        f.rv = 32'sh10000;
        pending_faces.push_back(f);
        f.rcx = 32'sh0;
        f.rcy = -32'sh10000;
        f.lsx = 32'sh30000;
        f.rsy = 32'sh7FFFFFFF;
        pending_faces.push_back(f);
        f = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh7FFFFFFF};
        pending_faces.push_back(f);
        f = '{32'sh7FFFFFFF, 32'sh0, 32'sh80000000, 32'sh1,
              32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000};
        pending_faces.push_back(f);
        // tiny distance with a large jump saturates
        f = fill_face(32'sh0);
        f.rcx = 32'sh1;
        f.rv = 32'sh7FFFFFFF;
        f.lv = 32'sh80000000;
        pending_faces.push_back(f);
        f.rcx = -32'sh1;
        pending_faces.push_back(f);
        f = fill_face(32'sh12345678);
        f.lsx = 32'shEDCBA987;
        pending_faces.push_back(f);
        for (int i = 0; i < 8; i++)
            pending_faces.push_back(random_face());
        drain();

        // hold the sender until everything has drained
        hold_send = 1'b1;
        for (int i = 0; i < 20; i++)
            pending_faces.push_back(random_face());
        drain_results: while (expected_gradients.size() > 0) @(posedge clk);
        hold_send = 1'b0;

        for (int i = 0; i < 260; i++)
            pending_faces.push_back(random_face());
        drain();
        send_idle_pct = 84;
        recv_idle_pct = 20;
        for (int i = 0; i < 260; i++)
            pending_faces.push_back(random_face());
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 260; i++)
            pending_faces.push_back(random_face());
        drain();
        repeat (120) @(posedge clk);

        $display("Checked %0d face transactions, %0d of them flagged out of range,",
                 popped, sat_seen);
        $display("under three sender/receiver stall mixes plus a full drain pause.");
        if (errors == 0)
            $display("[face_gradient_modified_average] OK");
        else
            $display("[face_gradient_modified_average] ERROR");
        $finish;
    end

    // generous cycle limit
    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("[face_gradient_modified_average] ERROR");
            $finish;
        end
    end

endmodule
